@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset.
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/mnt_pkg.sv @@
// Types, constants and fixed-point helpers of the MAT(2) neuron tick update.
package mnt_pkg;

  localparam int VAL_W = 32;
  localparam int ACC_W = 40;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;

  // Q1.30 decay coefficients of the currents and threshold parts
  localparam logic [30:0] EXCIT_DECAY = 31'd971553000;
  localparam logic [30:0] INHIB_DECAY = 31'd1038540000;
  localparam logic [30:0] SHORT_DECAY = 31'd1063058000;
  localparam logic [30:0] LONG_DECAY  = 31'd1073205000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEMBRANE_FACTOR  = 3'd0,
    REG_EXCIT_GAIN       = 3'd1,
    REG_INHIB_GAIN       = 3'd2,
    REG_CURRENT_GAIN     = 3'd3,
    REG_REST_THRESHOLD   = 3'd4,
    REG_SHORT_JUMP       = 3'd5,
    REG_LONG_JUMP        = 3'd6,
    REG_REFRACTORY_STEPS = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0]        membrane_factor;
    logic signed [31:0] excit_gain;
    logic signed [31:0] inhib_gain;
    logic signed [31:0] current_gain;
    logic signed [31:0] rest_threshold;
    logic [30:0]        short_jump;
    logic [30:0]        long_jump;
    logic [CNT_W-1:0]   refractory_steps;
  } cfg_t;

  typedef struct packed {
    logic [30:0]        excit_weight;
    logic signed [31:0] inhib_weight;
    logic signed [31:0] injected_current;
  } item_t;

  typedef struct packed {
    logic               spike;
    logic signed [31:0] membrane_potential;
    logic signed [31:0] threshold;
  } result_t;

  // value * coef / 2^30, round half up
  function automatic logic signed [ACC_W-1:0] qmul(input logic signed [31:0] val,
                                                   input logic signed [32:0] coef);
    logic signed [65:0] p;
    p = 66'(val) * 66'(coef);
    p = p + (66'sd1 <<< 29);
    return ACC_W'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      return v[31:0];
    end else if (v[ACC_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sx(input logic signed [31:0] v);
    return ACC_W'(v);
  endfunction

  function automatic logic signed [ACC_W-1:0] zx31(input logic [30:0] v);
    return $signed({{(ACC_W-31){1'b0}}, v});
  endfunction

  function automatic logic signed [32:0] ucoef(input logic [30:0] c);
    return $signed({2'b00, c});
  endfunction

  function automatic logic signed [32:0] scoef(input logic signed [31:0] c);
    return 33'(c);
  endfunction

endpackage

@@ rtl/mat2_neuron_tick_update_top.sv @@
// Top level of the MAT(2) adaptive-threshold neuron tick update.
//
// One input beat is one simulation tick: excitatory and inhibitory weight
// sums plus the injected current, which takes effect on the following tick.
// Each tick yields exactly one result beat: spike flag, membrane potential
// and the current threshold, the last two in Q16.16.
// Channels: in_* and out_* use valid/ready; a beat moves when both are high.
// cfg_* writes one register per beat, index as listed in mnt_pkg; cfg_ready
// is always high. Write configuration only while no tick is in flight.
// The input register loads at the input beat; the update loads the result
// register when the held tick advances, which a stalled receiver can delay.
// Throughput: one tick per cycle while the receiver keeps up, set by the
// combinational state update through four parallel 32x33 multipliers
// feeding one saturating sum and the threshold compare.
// A stalled receiver holds the result register; one more tick waits in the
// input register, then in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) clears the neuron state, empties both
// registers and restores the default configuration.
module mat2_neuron_tick_update_top
  import mnt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [30:0]          in_excit_weight,
  input  logic signed [31:0]   in_inhib_weight,
  input  logic signed [31:0]   in_injected_current,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_spike,
  output logic signed [31:0]   out_membrane_potential,
  output logic signed [31:0]   out_threshold,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  result_t res, res_r;
  logic    in_v_r, out_v_r;
  logic    step;

  assign cfg_ready = 1'b1;

  mnt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance a held tick when the result register is free or being drained
  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  mnt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (step) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.excit_weight     <= in_excit_weight;
      item_r.inhib_weight     <= in_inhib_weight;
      item_r.injected_current <= in_injected_current;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_v_r;
  assign out_spike              = res_r.spike;
  assign out_membrane_potential = res_r.membrane_potential;
  assign out_threshold          = res_r.threshold;

endmodule

@@ rtl/mnt_cfg.sv @@
// Configuration register file of the neuron tick update.
module mnt_cfg
  import mnt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_MEMBRANE_FACTOR:  cfg_nxt.membrane_factor  = wr_data[30:0];
        REG_EXCIT_GAIN:       cfg_nxt.excit_gain       = wr_data;
        REG_INHIB_GAIN:       cfg_nxt.inhib_gain       = wr_data;
        REG_CURRENT_GAIN:     cfg_nxt.current_gain     = wr_data;
        REG_REST_THRESHOLD:   cfg_nxt.rest_threshold   = wr_data;
        REG_SHORT_JUMP:       cfg_nxt.short_jump       = wr_data[30:0];
        REG_LONG_JUMP:        cfg_nxt.long_jump        = wr_data[30:0];
        REG_REFRACTORY_STEPS: cfg_nxt.refractory_steps = wr_data[CNT_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.membrane_factor  <= 31'd1052481000;
      cfg_r.excit_gain       <= 32'sd1011500;
      cfg_r.inhib_gain       <= 32'sd1045500;
      cfg_r.current_gain     <= 32'sd1063100;
      cfg_r.rest_threshold   <= 32'sd1245184;
      cfg_r.short_jump       <= 31'd2424832;
      cfg_r.long_jump        <= 31'd131072;
      cfg_r.refractory_steps <= 16'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/mnt_core.sv @@
// Neuron state registers and the one-tick update datapath.
module mnt_core
  import mnt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);

  logic signed [31:0] pot_r, ec_r, ic_r, hc_r, ts_r, tl_r;
  logic signed [31:0] pot_nxt, ec_nxt, ic_nxt, ts_nxt, tl_nxt;
  logic [CNT_W-1:0]   rc_r, rc_nxt;

  logic signed [ACC_W-1:0] pot_sum, th_exact;
  logic signed [31:0]      ts_dec, tl_dec;
  logic                    fire;

  always_comb begin
    pot_sum = qmul(pot_r, ucoef(cfg.membrane_factor))
            + qmul(ec_r, scoef(cfg.excit_gain))
            + qmul(ic_r, scoef(cfg.inhib_gain))
            + qmul(hc_r, scoef(cfg.current_gain));
    pot_nxt = sat32(pot_sum);

    ts_dec = sat32(qmul(ts_r, ucoef(SHORT_DECAY)));
    tl_dec = sat32(qmul(tl_r, ucoef(LONG_DECAY)));

    ec_nxt = sat32(qmul(ec_r, ucoef(EXCIT_DECAY)) + zx31(item.excit_weight));
    ic_nxt = sat32(qmul(ic_r, ucoef(INHIB_DECAY)) + sx(item.inhib_weight));

    // firing compares against the unsaturated threshold sum
    th_exact = sx(cfg.rest_threshold) + sx(ts_dec) + sx(tl_dec);
    fire = (rc_r == '0) && (sx(pot_nxt) >= th_exact);

    if (fire) begin
      rc_nxt = cfg.refractory_steps;
      ts_nxt = sat32(sx(ts_dec) + zx31(cfg.short_jump));
      tl_nxt = sat32(sx(tl_dec) + zx31(cfg.long_jump));
    end else begin
      rc_nxt = (rc_r == '0) ? rc_r : rc_r - CNT_W'(1);
      ts_nxt = ts_dec;
      tl_nxt = tl_dec;
    end

    res.spike              = fire;
    res.membrane_potential = pot_nxt;
    res.threshold          = sat32(sx(cfg.rest_threshold) + sx(ts_nxt) + sx(tl_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r <= '0;
      ec_r  <= '0;
      ic_r  <= '0;
      hc_r  <= '0;
      ts_r  <= '0;
      tl_r  <= '0;
      rc_r  <= '0;
    end else if (step) begin
      pot_r <= pot_nxt;
      ec_r  <= ec_nxt;
      ic_r  <= ic_nxt;
      hc_r  <= item.injected_current;
      ts_r  <= ts_nxt;
      tl_r  <= tl_nxt;
      rc_r  <= rc_nxt;
    end
  end

endmodule

@@ rtl/mnt_checker.sv @@
// Port-level assertions of the neuron tick update, bound to the top level.
`include "assert_macros.svh"

module mnt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_spike,
  input logic signed [31:0] out_membrane_potential,
  input logic signed [31:0] out_threshold
);

  logic        out_stall;
  logic [64:0] out_beat;

  assign out_stall = out_valid && !out_ready;
  assign out_beat  = {out_spike, out_membrane_potential, out_threshold};

  // no result may be pending right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // with the result register empty the input side never stalls
  `ASSERT_RUN(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled, output empty")

  // a stalled result beat holds
  `ASSERT_RUN(a_out_hold, clk, rst_n, out_stall |=> (out_valid && $stable(out_beat)), "beat changed")

endmodule

bind mat2_neuron_tick_update_top mnt_checker u_mnt_checker (.*);

@@ tb/sv/testbench.sv @@
// Testbench for the MAT(2) neuron tick update: directed and random ticks checked against a tick predictor.
`timescale 1ns / 100ps

module testbench;
  import mnt_pkg::*;

  localparam longint EXC_DECAY_Q30   = 971553000;
  localparam longint INH_DECAY_Q30   = 1038540000;
  localparam longint SHORT_DECAY_Q30 = 1063058000;
  localparam longint LONG_DECAY_Q30  = 1073205000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  class neuron_scoreboard;
    logic [30:0]        mem_factor;
    logic signed [31:0] exc_gain;
    logic signed [31:0] inh_gain;
    logic signed [31:0] cur_gain;
    logic signed [31:0] rest_th;
    logic [30:0]        short_jump;
    logic [30:0]        long_jump;
    logic [15:0]        refr_steps;

    logic signed [31:0] v_mem;
    logic signed [31:0] i_exc;
    logic signed [31:0] i_inh;
    logic signed [31:0] i_held;
    logic signed [31:0] th_short;
    logic signed [31:0] th_long;
    logic [15:0]        refr_left;

    result_t expected_ticks[$];
    int errors;

    function new();
      mem_factor = 31'd1052481000;
      exc_gain   = 32'sd1011500;
      inh_gain   = 32'sd1045500;
      cur_gain   = 32'sd1063100;
      rest_th    = 32'sd1245184;
      short_jump = 31'd2424832;
      long_jump  = 31'd131072;
      refr_steps = 16'd20;
      v_mem      = '0;
      i_exc      = '0;
      i_inh      = '0;
      i_held     = '0;
      th_short   = '0;
      th_long    = '0;
      refr_left  = '0;
      errors     = 0;
    endfunction

    // value * coef / 2^30, round half up
    function longint mul_q30(longint val, longint coef);
      longint p;
      p = val * coef + (longint'(1) <<< 29);
      return p >>> 30;
    endfunction

    function logic signed [31:0] clamp_s32(longint v);
      if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
      if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_MEMBRANE_FACTOR:  mem_factor = data[30:0];
        REG_EXCIT_GAIN:       exc_gain = data;
        REG_INHIB_GAIN:       inh_gain = data;
        REG_CURRENT_GAIN:     cur_gain = data;
        REG_REST_THRESHOLD:   rest_th = data;
        REG_SHORT_JUMP:       short_jump = data[30:0];
        REG_LONG_JUMP:        long_jump = data[30:0];
        REG_REFRACTORY_STEPS: refr_steps = data[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void note_tick(item_t t);
      longint sum_v;
      longint bound;
      result_t r;
      sum_v = mul_q30(v_mem, mem_factor) + mul_q30(i_exc, exc_gain)
            + mul_q30(i_inh, inh_gain) + mul_q30(i_held, cur_gain);
      v_mem    = clamp_s32(sum_v);
      th_short = clamp_s32(mul_q30(th_short, SHORT_DECAY_Q30));
      th_long  = clamp_s32(mul_q30(th_long, LONG_DECAY_Q30));
      i_exc    = clamp_s32(mul_q30(i_exc, EXC_DECAY_Q30) + longint'(t.excit_weight));
      i_inh    = clamp_s32(mul_q30(i_inh, INH_DECAY_Q30)
                           + longint'($signed(t.inhib_weight)));
      r.spike = 1'b0;
      if (refr_left == 16'd0) begin
        // compare against the unsaturated threshold sum
        bound = longint'(rest_th) + longint'(th_short) + longint'(th_long);
        if (longint'(v_mem) >= bound) begin
          r.spike   = 1'b1;
          refr_left = refr_steps;
          th_short  = clamp_s32(longint'(th_short) + longint'(short_jump));
          th_long   = clamp_s32(longint'(th_long) + longint'(long_jump));
        end
      end else begin
        refr_left = refr_left - 16'd1;
      end
      i_held = t.injected_current;
      r.membrane_potential = v_mem;
      r.threshold = clamp_s32(longint'(rest_th) + longint'(th_short) + longint'(th_long));
      expected_ticks.push_back(r);
    endfunction

    function void check_tick(result_t got);
      result_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result beat with no tick pending", $time);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.spike !== want.spike || got.membrane_potential !== want.membrane_potential ||
          got.threshold !== want.threshold) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: exp spike %0b pot %0d th %0d, got spike %0b pot %0d th %0d",
                   $time, want.spike, want.membrane_potential, want.threshold,
                   got.spike, got.membrane_potential, got.threshold);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [30:0]          in_excit_weight = '0;
  logic signed [31:0]   in_inhib_weight = '0;
  logic signed [31:0]   in_injected_current = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_spike;
  logic signed [31:0]   out_membrane_potential;
  logic signed [31:0]   out_threshold;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic        steady = 1'b0;
  int unsigned cycle_count = 0;
  neuron_scoreboard sb;

  mat2_neuron_tick_update_top u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_excit_weight        (in_excit_weight),
    .in_inhib_weight        (in_inhib_weight),
    .in_injected_current    (in_injected_current),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_spike              (out_spike),
    .out_membrane_potential (out_membrane_potential),
    .out_threshold          (out_threshold),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 29);

  always @(posedge clk) begin : monitor
    item_t   tick_in;
    result_t tick_out;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) begin
        tick_in.excit_weight     = in_excit_weight;
        tick_in.inhib_weight     = in_inhib_weight;
        tick_in.injected_current = in_injected_current;
        sb.note_tick(tick_in);
      end
      if (out_valid && out_ready) begin
        tick_out.spike              = out_spike;
        tick_out.membrane_potential = out_membrane_potential;
        tick_out.threshold          = out_threshold;
        sb.check_tick(tick_out);
      end
    end
  end

  task automatic send_tick(input logic [30:0] ew, input logic [31:0] iw, input logic [31:0] cur);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 29) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(2, 8) : 1;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_excit_weight     <= ew;
    in_inhib_weight     <= iw;
    in_injected_current <= cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly spike trains of bounded size, some raw noise
  task automatic send_random_tick(input int unsigned scale);
    logic [30:0] ew;
    logic [31:0] iw;
    logic [31:0] cur;
    if ($urandom_range(99) < 15) begin
      ew  = 31'($urandom);
      iw  = $urandom;
      cur = $urandom;
    end else begin
      ew  = ($urandom_range(99) < 45) ? 31'($urandom_range(0, scale)) : '0;
      iw  = ($urandom_range(99) < 30) ? -32'($urandom_range(0, scale)) : '0;
      cur = 32'($urandom_range(0, scale / 4)) - 32'(scale / 8);
    end
    send_tick(ew, iw, cur);
  endtask

  task automatic run_random(input int count, input int unsigned scale);
    repeat (count) send_random_tick(scale);
  endtask

  // drop valid, then hold until every tick result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] mf, input logic [31:0] eg, input logic [31:0] ig,
                               input logic [31:0] cg, input logic [31:0] rt, input logic [31:0] sj,
                               input logic [31:0] lj, input logic [31:0] rs);
    write_reg(REG_MEMBRANE_FACTOR, mf);
    write_reg(REG_EXCIT_GAIN, eg);
    write_reg(REG_INHIB_GAIN, ig);
    write_reg(REG_CURRENT_GAIN, cg);
    write_reg(REG_REST_THRESHOLD, rt);
    write_reg(REG_SHORT_JUMP, sj);
    write_reg(REG_LONG_JUMP, lj);
    write_reg(REG_REFRACTORY_STEPS, rs);
  endtask

  function automatic logic [31:0] rand_gain();
    logic [31:0] g;
    if ($urandom_range(4) == 0) return $urandom;
    g = $urandom_range(0, 1 << 26);
    if ($urandom_range(4) == 0) g = -g;
    return g;
  endfunction

  task automatic load_random_settings();
    logic [31:0] mf;
    logic [31:0] rt;
    logic [31:0] sj;
    logic [31:0] lj;
    logic [31:0] rs;
    mf = ($urandom_range(3) == 0) ? $urandom : $urandom_range(900000000, 1073741824);
    rt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 23);
    sj = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 23);
    lj = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 21);
    rs = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 40);
    load_settings(mf, rand_gain(), rand_gain(), rand_gain(), rt, sj, lj, rs);
  endtask

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    int unsigned scale;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks on the reset settings
    send_tick('0, '0, '0);
    send_tick(31'h7fff_ffff, '0, 32'h7fff_ffff);
    repeat (3) send_tick('0, '0, '0);
    send_tick('0, 32'h8000_0000, 32'h8000_0000);
    repeat (2) send_tick('0, '0, '0);
    send_tick('0, 32'h7fff_ffff, '0);
    send_tick(31'h7fff_ffff, 32'h8000_0000, '0);
    repeat (5) send_tick(31'd3000000, '0, 32'd65536);
    send_tick(31'd1, 32'hffff_ffff, 32'hffff_ffff);
    repeat (3) send_tick('0, '0, 32'h7fff_ffff);
    run_random(200, 1 << 22);
    wait_idle();

    // unit membrane factor, strong gains, zero refractory time
    load_settings(32'h4000_0000, 32'h2000_0000, 32'h2000_0000, 32'h1000_0000,
                  32'd1245184, 32'd2424832, 32'd131072, 32'd0);
    run_random(150, 1 << 16);
    wait_idle();

    // zero membrane factor, extreme gains and jumps, longest refractory time
    load_settings(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd65535);
    run_random(150, 1 << 24);
    wait_idle();

    // unused upper bits set, highest resting threshold, no jumps, one refractory tick
    load_settings(32'hffff_ffff, 32'h0010_0000, 32'hfff0_0000, 32'h0008_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_0001);
    run_random(150, 1 << 24);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      load_random_settings();
      steady <= (ph == 2);
      scale = 1 << $urandom_range(16, 24);
      run_random(165, scale);
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mnt_pkg.sv
rtl/mnt_cfg.sv
rtl/mnt_core.sv
rtl/mat2_neuron_tick_update_top.sv
rtl/mnt_checker.sv
tb/sv/testbench.sv
